// ----- design/front_back_push_queue_core_macros.svh -----
// ----------------------------------------------------------------------------
// front_back_push_queue_core assertion macros
// clocked assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef FRONT_BACK_PUSH_QUEUE_CORE_MACROS_SVH
`define FRONT_BACK_PUSH_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// checked at every rising edge, masked while reset is high
`define FBQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fbq assertion failed");
// checked at every rising edge, also during reset
`define FBQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fbq assertion failed");
`else
`define FBQ_ASSERT(label, clk, rst, prop)
`define FBQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- design/fbq_pkg.sv -----
// ----------------------------------------------------------------------------
// fbq_pkg
// shared sizes, codes and control types of the front/back push queue
// ----------------------------------------------------------------------------
package fbq_pkg;

  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W    = $clog2(DEPTH);
  localparam int OCC_W    = $clog2(DEPTH + 1);
  localparam int SUM_W    = OCC_W + 1;

  localparam int REQ_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int ITEM_W   = 32;
  localparam int COUNT_W  = 6;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OCC_W-1:0] occ_t;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DUMP       = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                push_front;
    logic                push_back;
    logic                load_err;
    logic [STATUS_W-1:0] err_status;
    logic                rd_start;
    logic                rd_next;
    logic                pop_load;
    logic                dump_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic out_last;
  } stat_t;

  // ring position base + off, off below DEPTH
  function automatic idx_t ring_add(idx_t base, occ_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return IDX_W'(sum);
  endfunction

endpackage

// ----- design/fbq_req_if.sv -----
// ----------------------------------------------------------------------------
// fbq_req_if
// request channel: valid/ready with request type and push word
// ----------------------------------------------------------------------------
interface fbq_req_if;
  logic                                valid;
  logic                                ready;
  logic [fbq_pkg::REQ_W-1:0]           req_type;
  logic signed [fbq_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ----- design/fbq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fbq_rsp_if
// result channel: valid/ready with status, word, last marker and count
// ----------------------------------------------------------------------------
interface fbq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [fbq_pkg::STATUS_W-1:0]        status;
  logic signed [fbq_pkg::ITEM_W-1:0]   item;
  logic                                last;
  logic [fbq_pkg::COUNT_W-1:0]         count;

  modport source (output valid, output status, output item, output last,
                  output count, input ready);
  modport sink   (input valid, input status, input item, input last,
                  input count, output ready);
endinterface

// ----- design/fbq_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbq_ctrl
// sequencer: decodes requests, steps pops and dumps, owns the handshakes
// ----------------------------------------------------------------------------
module fbq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic [fbq_pkg::REQ_W-1:0] req_type,
  output logic                      req_ready,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  input  fbq_pkg::stat_t            stat,
  output fbq_pkg::cmd_t             cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_OUT   = 5'b00100,
    S_DRD   = 5'b01000,
    S_DOUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (req_type)
            fbq_pkg::REQ_PUSH_FRONT, fbq_pkg::REQ_PUSH_BACK: begin
              if (stat.full) begin
                cmd.load_err   = 1'b1;
                cmd.err_status = fbq_pkg::ST_FULL;
              end else begin
                cmd.push_front = (req_type == fbq_pkg::REQ_PUSH_FRONT);
                cmd.push_back  = (req_type == fbq_pkg::REQ_PUSH_BACK);
              end
              state_next = S_OUT;
            end
            fbq_pkg::REQ_POP_FRONT: begin
              if (stat.empty) begin
                cmd.load_err   = 1'b1;
                cmd.err_status = fbq_pkg::ST_EMPTY;
                state_next     = S_OUT;
              end else begin
                cmd.rd_start = 1'b1;
                state_next   = S_POP;
              end
            end
            fbq_pkg::REQ_DUMP: begin
              // empty dump completes silently
              if (!stat.empty) begin
                cmd.rd_start = 1'b1;
                state_next   = S_DRD;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      S_DRD: begin
        cmd.dump_load = 1'b1;
        state_next    = S_DOUT;
      end
      S_DOUT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          if (stat.out_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = S_DRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/fbq_dp.sv -----
// ----------------------------------------------------------------------------
// fbq_dp
// ring store, front pointer, occupancy, dump cursor and result register
// ----------------------------------------------------------------------------
module fbq_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  fbq_pkg::cmd_t                      cmd,
  output fbq_pkg::stat_t                     stat,
  input  logic signed [fbq_pkg::VALUE_W-1:0] value,
  output logic [fbq_pkg::STATUS_W-1:0]       status,
  output logic signed [fbq_pkg::ITEM_W-1:0]  item,
  output logic                               last,
  output logic [fbq_pkg::COUNT_W-1:0]        count
);

  logic signed [fbq_pkg::DATA_WIDTH-1:0] mem [fbq_pkg::DEPTH];
  logic signed [fbq_pkg::DATA_WIDTH-1:0] rd_q;

  fbq_pkg::idx_t front, front_next;
  fbq_pkg::occ_t occ, occ_next;
  fbq_pkg::idx_t idx, idx_next;

  fbq_pkg::idx_t front_dec, front_inc, back_pos, wr_addr, rd_addr;
  fbq_pkg::occ_t occ_inc, occ_dec, idx_plus;
  logic          wr_en;
  logic          rd_en;
  logic          dump_last;

  assign front_dec = (front == '0) ? fbq_pkg::IDX_W'(fbq_pkg::DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == fbq_pkg::IDX_W'(fbq_pkg::DEPTH - 1)) ? '0 : front + 1'b1;
  assign back_pos  = fbq_pkg::ring_add(front, occ);
  assign occ_inc   = occ + 1'b1;
  assign occ_dec   = occ - 1'b1;
  assign idx_plus  = fbq_pkg::OCC_W'(idx) + 1'b1;
  assign dump_last = (idx_plus == occ);

  assign wr_en   = cmd.push_front | cmd.push_back;
  assign wr_addr = cmd.push_front ? front_dec : back_pos;
  assign rd_en   = cmd.rd_start | cmd.rd_next;
  assign rd_addr = cmd.rd_start ? front : fbq_pkg::ring_add(front, idx_plus);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= fbq_pkg::DATA_WIDTH'(value);
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    front_next = front;
    occ_next   = occ;
    idx_next   = idx;
    if (cmd.push_front) begin
      front_next = front_dec;
      occ_next   = occ_inc;
    end
    if (cmd.push_back) begin
      occ_next = occ_inc;
    end
    if (cmd.pop_load) begin
      front_next = front_inc;
      occ_next   = occ_dec;
    end
    if (cmd.rd_start) begin
      idx_next = '0;
    end
    if (cmd.rd_next) begin
      idx_next = idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      occ   <= '0;
      idx   <= '0;
    end else begin
      front <= front_next;
      occ   <= occ_next;
      idx   <= idx_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      status <= fbq_pkg::ST_OK;
      item   <= '0;
      last   <= 1'b1;
      count  <= fbq_pkg::COUNT_W'(occ_inc);
    end else if (cmd.load_err) begin
      status <= cmd.err_status;
      item   <= '0;
      last   <= 1'b1;
      count  <= fbq_pkg::COUNT_W'(occ);
    end else if (cmd.pop_load) begin
      status <= fbq_pkg::ST_OK;
      item   <= fbq_pkg::ITEM_W'(rd_q);
      last   <= 1'b1;
      count  <= fbq_pkg::COUNT_W'(occ_dec);
    end else if (cmd.dump_load) begin
      status <= fbq_pkg::ST_OK;
      item   <= fbq_pkg::ITEM_W'(rd_q);
      last   <= dump_last;
      count  <= fbq_pkg::COUNT_W'(occ);
    end
  end

  assign stat.full     = (occ == fbq_pkg::OCC_W'(fbq_pkg::DEPTH));
  assign stat.empty    = (occ == '0);
  assign stat.out_last = last;

endmodule

// ----- design/front_back_push_queue_core.sv -----
// ----------------------------------------------------------------------------
// front_back_push_queue_core
// output-restricted deque: push front/back, pop front, dump front to back
// ----------------------------------------------------------------------------
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, value
//   rsp      out  valid/ready   status, item, last, count
//
// a push or an error result is in the result register in the cycle after the
// request; a pop passes the registered store read before the result load.
// a dump gives its results one by one (store read, then result load).
// one request is in flight at a time; req.ready is low until its last
// result is taken. a stalled result holds the block.
// reset clears front pointer and occupancy; the store is not cleared.
// ----------------------------------------------------------------------------
`include "front_back_push_queue_core_macros.svh"

module front_back_push_queue_core (
  input  logic      clk,
  input  logic      rst,
  fbq_req_if.sink   req,
  fbq_rsp_if.source rsp
);

  fbq_pkg::cmd_t  cmd;
  fbq_pkg::stat_t stat;
  logic           req_ready;
  logic           rsp_valid;

  fbq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fbq_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .value  (req.value),
    .status (rsp.status),
    .item   (rsp.item),
    .last   (rsp.last),
    .count  (rsp.count)
  );

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

  // no request taken while a result is pending
  `FBQ_ASSERT(a_one_in_flight, clk, rst, (req.valid && req.ready) |-> !rsp.valid)
  // push into a full store reports full next cycle
  `FBQ_ASSERT(a_full_resp, clk, rst, (req.valid && req.ready && stat.full && (req.req_type == fbq_pkg::REQ_PUSH_FRONT || req.req_type == fbq_pkg::REQ_PUSH_BACK)) |=> (rsp.valid && rsp.status == fbq_pkg::ST_FULL))
  // pop of an empty store reports empty with zero count
  `FBQ_ASSERT(a_empty_resp, clk, rst, (req.valid && req.ready && stat.empty && req.req_type == fbq_pkg::REQ_POP_FRONT) |=> (rsp.valid && rsp.status == fbq_pkg::ST_EMPTY && rsp.count == '0))

endmodule

// ----- tb/front_back_push_queue_core_tb.sv -----
// ----------------------------------------------------------------------------
// front_back_push_queue_core_tb
// A shadow ring of words predicts every result of the push front, push back,
// pop front and dump requests. Each result taken from the block is checked
// field by field against the oldest prediction. Stimulus is a short directed
// pass followed by random fill, drain and mixed episodes. Both channels
// idle at random, apart from one stretch with no gaps.
// ----------------------------------------------------------------------------
module front_back_push_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [fbq_pkg::REQ_W-1:0]   kind;
    logic [fbq_pkg::VALUE_W-1:0] word;
    logic                        hold;
  } request_t;

  typedef struct packed {
    logic [fbq_pkg::STATUS_W-1:0] status;
    logic [fbq_pkg::ITEM_W-1:0]   item;
    logic                         last;
    logic [fbq_pkg::COUNT_W-1:0]  count;
  } result_t;

  logic clk;
  logic rst = 1'b1;

  fbq_req_if req_ch ();
  fbq_rsp_if rsp_ch ();

  front_back_push_queue_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow deque
  logic [fbq_pkg::DATA_WIDTH-1:0] ring_words [fbq_pkg::DEPTH];
  int unsigned                    head_pos;
  int unsigned                    fill_level;

  request_t    send_list [$];
  result_t     owed_results [$];
  int unsigned sent_count;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned plan_occ;
  logic        calm;
  request_t    next_req;

  assign calm = (sent_count >= 220) && (sent_count < 330);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [fbq_pkg::ITEM_W-1:0] widen(logic [fbq_pkg::DATA_WIDTH-1:0] w);
    logic signed [fbq_pkg::DATA_WIDTH-1:0] s;
    s = w;
    return fbq_pkg::ITEM_W'(s);
  endfunction

  task automatic owe(logic [fbq_pkg::STATUS_W-1:0] status,
                     logic [fbq_pkg::ITEM_W-1:0] item,
                     logic last, int unsigned level);
    result_t r;
    r.status = status;
    r.item   = item;
    r.last   = last;
    r.count  = fbq_pkg::COUNT_W'(level);
    owed_results.push_back(r);
  endtask

  task automatic model_request(logic [fbq_pkg::REQ_W-1:0] kind,
                               logic [fbq_pkg::VALUE_W-1:0] word);
    case (kind)
      fbq_pkg::REQ_PUSH_FRONT, fbq_pkg::REQ_PUSH_BACK: begin
        if (fill_level >= fbq_pkg::DEPTH) begin
          owe(fbq_pkg::ST_FULL, '0, 1'b1, fill_level);
        end else begin
          if (kind == fbq_pkg::REQ_PUSH_FRONT) begin
            head_pos = (head_pos + fbq_pkg::DEPTH - 1) % fbq_pkg::DEPTH;
            ring_words[head_pos] = fbq_pkg::DATA_WIDTH'(word);
          end else begin
            ring_words[(head_pos + fill_level) % fbq_pkg::DEPTH] =
              fbq_pkg::DATA_WIDTH'(word);
          end
          fill_level++;
          owe(fbq_pkg::ST_OK, '0, 1'b1, fill_level);
        end
      end
      fbq_pkg::REQ_POP_FRONT: begin
        if (fill_level == 0) begin
          owe(fbq_pkg::ST_EMPTY, '0, 1'b1, 0);
        end else begin
          fill_level--;
          owe(fbq_pkg::ST_OK, widen(ring_words[head_pos]), 1'b1, fill_level);
          head_pos = (head_pos + 1) % fbq_pkg::DEPTH;
        end
      end
      default: begin
        // dump of an empty deque owes nothing
        for (int i = 0; i < fill_level; i++) begin
          owe(fbq_pkg::ST_OK, widen(ring_words[(head_pos + i) % fbq_pkg::DEPTH]),
              i + 1 == fill_level, fill_level);
        end
      end
    endcase
  endtask

  function automatic logic [fbq_pkg::VALUE_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add(logic [fbq_pkg::REQ_W-1:0] kind, logic [fbq_pkg::VALUE_W-1:0] word,
                     logic hold = 1'b0);
    request_t r;
    r.kind = kind;
    r.word = word;
    r.hold = hold;
    send_list.push_back(r);
    if (kind == fbq_pkg::REQ_PUSH_FRONT || kind == fbq_pkg::REQ_PUSH_BACK) begin
      if (plan_occ < fbq_pkg::DEPTH) plan_occ++;
    end else if (kind == fbq_pkg::REQ_POP_FRONT) begin
      if (plan_occ > 0) plan_occ--;
    end
  endtask

  function automatic logic [fbq_pkg::REQ_W-1:0] rand_push();
    return $urandom_range(1) ? fbq_pkg::REQ_PUSH_FRONT : fbq_pkg::REQ_PUSH_BACK;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= fbq_pkg::REQ_PUSH_FRONT;
      req_ch.value    <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        model_request(req_ch.req_type, req_ch.value);
        sent_count++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_list.size() != 0 && (!send_list[0].hold || owed_results.size() == 0) &&
            (calm || $urandom_range(99) >= 25)) begin
          next_req = send_list.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.req_type <= next_req.kind;
          req_ch.value    <= next_req.word;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_results.size() == 0) begin
          $display({"%0t ns: unexpected result, expected none, ",
                    "actual status %0d item %h last %0d count %0d"},
                   $time, rsp_ch.status, rsp_ch.item, rsp_ch.last, rsp_ch.count);
          mismatch_count++;
        end else begin
          check_field("status", 32'(owed_results[0].status), 32'(rsp_ch.status));
          check_field("item", 32'(owed_results[0].item), 32'(rsp_ch.item));
          check_field("last", 32'(owed_results[0].last), 32'(rsp_ch.last));
          check_field("count", 32'(owed_results[0].count), 32'(rsp_ch.count));
          void'(owed_results.pop_front());
        end
      end
      rsp_ch.ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned n_random;
    int unsigned episode;
    int unsigned pick;
    int unsigned total_items;
    head_pos       = 0;
    fill_level     = 0;
    sent_count     = 0;
    mismatch_count = 0;
    plan_occ       = 0;

    // directed: empty cases, extreme words, order of front and back pushes
    add(fbq_pkg::REQ_POP_FRONT, 32'h1234_5678);
    add(fbq_pkg::REQ_DUMP, '0);
    add(fbq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
    add(fbq_pkg::REQ_PUSH_BACK, 32'h7fff_ffff);
    add(fbq_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
    add(fbq_pkg::REQ_PUSH_BACK, 32'hffff_ffff);
    add(fbq_pkg::REQ_PUSH_FRONT, 32'haaaa_aaaa);
    add(fbq_pkg::REQ_PUSH_BACK, 32'h5555_5555);
    add(fbq_pkg::REQ_DUMP, 32'hffff_ffff);
    add(fbq_pkg::REQ_POP_FRONT, '0);
    add(fbq_pkg::REQ_PUSH_BACK, $urandom);
    repeat (7) add(fbq_pkg::REQ_POP_FRONT, $urandom);
    add(fbq_pkg::REQ_DUMP, $urandom);

    // random episodes; the first fills to full after a drain pause
    n_random = 0;
    episode  = 0;
    while (n_random < 500) begin
      pick = (episode == 0) ? 0 : $urandom_range(9);
      if (pick <= 1) begin
        add(rand_push(), rand_word(), episode == 0 || episode == 7);
        n_random++;
        while (plan_occ < fbq_pkg::DEPTH) begin
          add(rand_push(), rand_word());
          n_random++;
        end
        repeat ($urandom_range(3, 1)) begin
          add(rand_push(), rand_word());
          n_random++;
        end
        add(fbq_pkg::REQ_DUMP, rand_word());
        n_random++;
      end else if (pick <= 3) begin
        add(fbq_pkg::REQ_POP_FRONT, rand_word(), episode == 7);
        n_random++;
        while (plan_occ > 0) begin
          add(fbq_pkg::REQ_POP_FRONT, rand_word());
          n_random++;
        end
        repeat ($urandom_range(2, 1)) begin
          add(fbq_pkg::REQ_POP_FRONT, rand_word());
          n_random++;
        end
        add(fbq_pkg::REQ_DUMP, rand_word());
        n_random++;
      end else begin
        repeat ($urandom_range(30, 8)) begin
          pick = $urandom_range(99);
          if (pick < 30) add(fbq_pkg::REQ_PUSH_FRONT, rand_word());
          else if (pick < 60) add(fbq_pkg::REQ_PUSH_BACK, rand_word());
          else if (pick < 88) add(fbq_pkg::REQ_POP_FRONT, rand_word());
          else add(fbq_pkg::REQ_DUMP, rand_word());
          n_random++;
        end
      end
      episode++;
    end
    total_items = send_list.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // every request taken and every owed result seen
    while (sent_count < total_items || owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/fbq_pkg.sv
design/fbq_req_if.sv
design/fbq_rsp_if.sv
design/fbq_ctrl.sv
design/fbq_dp.sv
design/front_back_push_queue_core.sv
tb/front_back_push_queue_core_tb.sv
